// File: src/windowed_message_deduplicator_unit_assert.svh
// Assertion macros for the windowed message deduplicator.
// Included by wmd_back, which checks its own logic; no other dependencies.
`ifndef WINDOWED_MESSAGE_DEDUPLICATOR_UNIT_ASSERT_SVH
`define WINDOWED_MESSAGE_DEDUPLICATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define WMD_ASSERT_NOW(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WMD_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/wmd_pkg.sv
// Shared types and sizes for the windowed message deduplicator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wmd_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int KEY_W    = 48;
  localparam int STAMP_W  = 32;
  localparam int WINDOW_W = 16;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
  } wmd_item_t;

  localparam int ITEM_W = $bits(wmd_item_t);

  typedef struct packed {
    logic evicted_live;
    logic pass_on;
  } wmd_result_t;

endpackage

`default_nettype wire

// File: src/wmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/wmd_front.sv
// Front end: accepts header words, forms the lookup key, and queues items.
// Depends on wmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wmd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [79:0]        s_tdata,
  output logic               q_valid,
  output wmd_pkg::wmd_item_t q_item,
  input  logic               q_pop
);
  import wmd_pkg::*;

  wmd_item_t  slot [2];
  wmd_item_t  in_item;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_item.key   = {s_tdata[7:0], s_tdata[15:8], s_tdata[39:16], s_tdata[47:40]};
  assign in_item.stamp = s_tdata[79:48];

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= in_item;
        wr_ptr       <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// File: src/wmd_back.sv
// Back end: scans the seen-key table, decides pass or drop, updates the table.
// Depends on wmd_pkg, wmd_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "windowed_message_deduplicator_unit_assert.svh"

module wmd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  wmd_pkg::wmd_item_t   q_item,
  output logic                 q_pop,
  input  logic [15:0]          window_ms,
  output logic                 out_valid,
  output wmd_pkg::wmd_result_t out_res,
  input  logic                 out_ready
);
  import wmd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  state_t               state;
  logic [CNT_W-1:0]     rd_cnt;
  logic [CNT_W-1:0]     fill;
  logic                 sa_v;
  logic [IDX_W-1:0]     sa_idx;
  logic                 sb_v;
  logic [IDX_W-1:0]     sb_idx;
  logic [STAMP_W-1:0]   sb_age;
  logic                 sb_eq;
  logic                 sb_vld;
  logic                 dup;
  logic                 same_f;
  logic [IDX_W-1:0]     same_idx;
  logic                 free_f;
  logic [IDX_W-1:0]     free_idx;
  logic [STAMP_W-1:0]   old_age;
  logic [IDX_W-1:0]     old_idx;

  wmd_item_t            rd_word;
  logic                 issue;
  logic [IDX_W-1:0]     rd_addr;
  logic [STAMP_W-1:0]   age_a;
  logic                 eq_a;
  logic                 vld_a;
  logic                 live_b;
  logic                 last_b;
  logic [IDX_W-1:0]     slot;
  logic                 evict;
  logic                 load;
  logic                 wr_en;

  assign issue   = (state == ST_SCAN) && (rd_cnt < CNT_W'(TABLE_ENTRIES));
  assign rd_addr = rd_cnt[IDX_W-1:0];
  assign age_a   = q_item.stamp - rd_word.stamp;
  assign eq_a    = (rd_word.key == q_item.key);
  assign vld_a   = (CNT_W'(sa_idx) < fill);
  assign live_b  = (sb_age <= {{(STAMP_W-WINDOW_W){1'b0}}, window_ms});
  assign last_b  = sb_v && (sb_idx == IDX_W'(TABLE_ENTRIES - 1));
  assign evict   = !same_f && !free_f;
  assign slot    = same_f ? same_idx : (free_f ? free_idx : old_idx);
  assign load    = (state == ST_FINISH) && (!out_valid || out_ready);
  assign wr_en   = load && !dup;
  assign q_pop   = load;

  wmd_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot),
    .wdata (q_item),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_cnt    <= '0;
      fill      <= '0;
      sa_v      <= 1'b0;
      sb_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          sa_v <= 1'b0;
          sb_v <= 1'b0;
          if (q_valid) begin
            rd_cnt <= '0;
            dup    <= 1'b0;
            same_f <= 1'b0;
            free_f <= 1'b0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end
          sa_v   <= issue;
          sa_idx <= rd_addr;
          sb_v   <= sa_v;
          sb_idx <= sa_idx;
          sb_age <= age_a;
          sb_eq  <= eq_a;
          sb_vld <= vld_a;
          if (sb_v) begin
            if (!sb_vld) begin
              if (!free_f) begin
                free_f   <= 1'b1;
                free_idx <= sb_idx;
              end
            end else begin
              if (sb_eq && live_b) begin
                dup <= 1'b1;
              end
              if (sb_eq && !live_b && !same_f) begin
                same_f   <= 1'b1;
                same_idx <= sb_idx;
              end
              if (!live_b && !free_f) begin
                free_f   <= 1'b1;
                free_idx <= sb_idx;
              end
              if (live_b && ((sb_idx == '0) || (sb_age > old_age))) begin
                old_age <= sb_age;
                old_idx <= sb_idx;
              end
            end
          end
          if (last_b) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (load) begin
            out_valid            <= 1'b1;
            out_res.pass_on      <= !dup;
            out_res.evicted_live <= !dup && evict;
            if (!dup && (CNT_W'(slot) == fill)) begin
              fill <= fill + CNT_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `WMD_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= CNT_W'(TABLE_ENTRIES),
                  "fill count beyond table size")
  `WMD_ASSERT_NOW(a_drop_no_evict, clk, rst, out_valid && !out_res.pass_on,
                  !out_res.evicted_live, "dropped word flagged as eviction")
  `WMD_ASSERT_NOW(a_evict_full, clk, rst, wr_en && evict,
                  fill == CNT_W'(TABLE_ENTRIES), "eviction with table not full")
  `WMD_ASSERT_NEXT(a_pop_idle, clk, rst, load, state == ST_IDLE,
                   "finish did not return to idle")

endmodule

`default_nettype wire

// File: src/windowed_message_deduplicator_unit.sv
// Windowed message deduplicator: one word is handled at a time, and each word
// is checked by a full scan of the table, one entry per cycle.
// One more input word can queue while a word is scanned or its result waits.
// Synchronous reset clears the table fill count (all entries free) and sets
// window_ms to 1000; table contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module windowed_message_deduplicator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // system_id[7:0], component_id[15:8], message_id[39:16],
  // sequence_number[47:40], time_ms[79:48]
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pass_on[0], evicted_live[1], zero[7:2]
  output logic [7:0]  m_tdata,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import wmd_pkg::*;

  logic [WINDOW_W-1:0] window_ms;
  logic                q_valid;
  wmd_item_t           q_item;
  logic                q_pop;
  wmd_result_t         out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_ms <= cfg_wdata;
    end
  end

  wmd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  wmd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .window_ms (window_ms),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .out_ready (m_tready)
  );

  assign m_tdata = {6'd0, out_res.evicted_live, out_res.pass_on};

endmodule

`default_nettype wire
